@@ sv/base64_line_wrapped_encoder_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Base64 line-wrapped encoder: assertion macros
// Shared concurrent assertion forms for the encoder modules.
// ----------------------------------------------------------------------------
`ifndef BASE64_LINE_WRAPPED_ENCODER_UNIT_MACROS_SVH
`define BASE64_LINE_WRAPPED_ENCODER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define B64E_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define B64E_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/b64e_pkg.sv @@
// ----------------------------------------------------------------------------
// Base64 line-wrapped encoder package
// Types, character constants and the alphabet lookup.
// ----------------------------------------------------------------------------
package b64e_pkg;

   localparam logic [7:0] PAD_CHAR      = 8'h3D;
   localparam logic [7:0] NEWLINE_CHAR  = 8'h0A;
   localparam logic [7:0] WIDTH_RESET   = 8'd72;
   localparam int         GROUP_MAX     = 4;

   localparam logic [1:0] PHASE_FIRST   = 2'd0;
   localparam logic [1:0] PHASE_SECOND  = 2'd1;
   localparam logic [1:0] PHASE_THIRD   = 2'd2;

   // Characters produced by one input transaction, oldest in entry 0
   typedef struct packed {
      logic [GROUP_MAX-1:0][7:0] chars;
      logic [2:0]                count;
   } b64e_group_type;

   // Standard alphabet: A-Z, a-z, 0-9, '+', '/'
   function automatic logic [7:0] b64e_symbol(input logic [5:0] v);
      logic [7:0] c;
      if (v < 6'd26) begin
         c = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
         c = 8'h61 + {2'b00, v - 6'd26};
      end else if (v < 6'd62) begin
         c = 8'h30 + {2'b00, v - 6'd52};
      end else if (v == 6'd62) begin
         c = 8'h2B;
      end else begin
         c = 8'h2F;
      end
      return c;
   endfunction

endpackage

@@ sv/b64e_core.sv @@
// ----------------------------------------------------------------------------
// Base64 encoder core
// Holds triple phase, previous byte and column count; works out the
// characters (symbols, pads and inserted newlines) for one transaction.
// ----------------------------------------------------------------------------
`include "base64_line_wrapped_encoder_unit_macros.svh"

module b64e_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [7:0]               in_byte,
   input  logic                     end_of_stream,
   input  logic [7:0]               line_width,
   output b64e_pkg::b64e_group_type group
);

   logic [1:0] phase_ff, phase_in;
   logic [7:0] prev_ff,  prev_in;
   logic [7:0] col_ff,   col_in;

   logic [2:0][7:0] sym;
   logic [1:0]      sym_count;
   logic [7:0][7:0] pend;
   logic [2:0]      pos;
   logic [7:0]      col;

   // Symbols and pads before line wrapping
   always_comb begin
      sym       = '0;
      sym_count = 2'd0;
      phase_in  = phase_ff;
      case (phase_ff)
         b64e_pkg::PHASE_SECOND: begin
            if (end_of_stream) begin
               sym[0]    = b64e_pkg::b64e_symbol({prev_ff[1:0], 4'b0000});
               sym[1]    = b64e_pkg::PAD_CHAR;
               sym[2]    = b64e_pkg::PAD_CHAR;
               sym_count = 2'd3;
            end else begin
               sym[0]    = b64e_pkg::b64e_symbol({prev_ff[1:0], in_byte[7:4]});
               sym_count = 2'd1;
               phase_in  = b64e_pkg::PHASE_THIRD;
            end
         end
         b64e_pkg::PHASE_THIRD: begin
            if (end_of_stream) begin
               sym[0]    = b64e_pkg::b64e_symbol({prev_ff[3:0], 2'b00});
               sym[1]    = b64e_pkg::PAD_CHAR;
               sym_count = 2'd2;
            end else begin
               sym[0]    = b64e_pkg::b64e_symbol({prev_ff[3:0], in_byte[7:6]});
               sym[1]    = b64e_pkg::b64e_symbol(in_byte[5:0]);
               sym_count = 2'd2;
               phase_in  = b64e_pkg::PHASE_FIRST;
            end
         end
         default: begin
            // a complete triple leaves nothing to flush
            if (!end_of_stream) begin
               sym[0]    = b64e_pkg::b64e_symbol(in_byte[7:2]);
               sym_count = 2'd1;
               phase_in  = b64e_pkg::PHASE_SECOND;
            end
         end
      endcase
      if (end_of_stream) begin
         phase_in = b64e_pkg::PHASE_FIRST;
      end
   end

   // Insert a newline after every character that fills the line
   always_comb begin
      pend = '0;
      pos  = 3'd0;
      col  = col_ff;
      for (int i = 0; i < 3; i++) begin
         if (2'(i) < sym_count) begin
            pend[pos] = sym[i];
            pos       = pos + 3'd1;
            col       = col + 8'd1;
            if (col >= line_width) begin
               pend[pos] = b64e_pkg::NEWLINE_CHAR;
               pos       = pos + 3'd1;
               col       = 8'd0;
            end
         end
      end
   end

   always_comb begin
      for (int k = 0; k < b64e_pkg::GROUP_MAX; k++) begin
         group.chars[k] = pend[k];
      end
      // drop anything beyond four characters
      group.count = (pos > 3'(b64e_pkg::GROUP_MAX)) ? 3'(b64e_pkg::GROUP_MAX) : pos;
      prev_in     = end_of_stream ? 8'd0 : in_byte;
      col_in      = end_of_stream ? 8'd0 : col;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= b64e_pkg::PHASE_FIRST;
         prev_ff  <= 8'd0;
         col_ff   <= 8'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         prev_ff  <= prev_in;
         col_ff   <= col_in;
      end
   end

   `B64E_ASSERT_NEXT(a_eos_clears, clock, reset, accept && end_of_stream,
      phase_ff == b64e_pkg::PHASE_FIRST && col_ff == 8'd0 && prev_ff == 8'd0,
      "end of stream did not clear state")
   `B64E_ASSERT_NEXT(a_triple_wraps, clock, reset,
      accept && !end_of_stream && phase_ff == b64e_pkg::PHASE_THIRD,
      phase_ff == b64e_pkg::PHASE_FIRST, "phase did not wrap after third byte")
   `B64E_ASSERT_NEXT(a_state_holds, clock, reset, !accept,
      $stable(phase_ff) && $stable(col_ff) && $stable(prev_ff),
      "state moved without a transaction")

endmodule

@@ sv/base64_line_wrapped_encoder_unit.sv @@
// ----------------------------------------------------------------------------
// Base64 line-wrapped encoder
// Byte stream in, Base64 characters with line wrapping out.
// ----------------------------------------------------------------------------
// Each request transaction carries one data byte, or an end-of-stream flag in
// tuser that flushes a partial triple with '=' pads and clears the encoder.
// A transaction gives zero to four characters, which leave one per cycle on
// the response channel while rsp_tready is high, tlast marking the final
// character of that transaction; a newline is inserted whenever the column
// count reaches the line width written on the csr channel (reset 72). The
// characters for a transaction are worked out in the cycle it is accepted
// and held in a four-entry output buffer; the next request is taken in the
// cycle the last buffered character is taken, or whenever the buffer is
// empty. The single-character output port bounds the throughput: on a
// continuous stream every newline takes an output slot of its own.
`include "base64_line_wrapped_encoder_unit_macros.svh"

module base64_line_wrapped_encoder_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tuser,   // [0] end_of_stream
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic       rsp_tlast,   // last
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data     // [7:0] line_width
);

   logic [7:0] width_ff;

   b64e_pkg::b64e_group_type group;
   logic [b64e_pkg::GROUP_MAX-1:0][7:0] chars_ff;
   logic [2:0] cnt_ff;
   logic [1:0] rd_ff;
   logic       req_fire, rsp_fire;

   assign csr_ready = 1'b1;

   assign rsp_tvalid = (cnt_ff != 3'd0);
   assign rsp_tdata  = chars_ff[rd_ff];
   assign rsp_tlast  = (cnt_ff == 3'd1);
   assign rsp_fire   = rsp_tvalid && rsp_tready;

   assign req_tready = (cnt_ff == 3'd0) || (cnt_ff == 3'd1 && rsp_tready);
   assign req_fire   = req_tvalid && req_tready;

   b64e_core u_core (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_fire),
      .in_byte       (req_tdata),
      .end_of_stream (req_tuser),
      .line_width    (width_ff),
      .group         (group)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= b64e_pkg::WIDTH_RESET;
      end else if (csr_valid && csr_ready) begin
         width_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 3'd0;
         rd_ff  <= 2'd0;
      end else begin
         if (rsp_fire) begin
            cnt_ff <= cnt_ff - 3'd1;
            rd_ff  <= rd_ff + 2'd1;
         end
         // load a new group over the drained buffer
         if (req_fire && group.count != 3'd0) begin
            cnt_ff <= group.count;
            rd_ff  <= 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && group.count != 3'd0) begin
         chars_ff <= group.chars;
      end
   end

   `B64E_ASSERT_NOW(a_count_bound, clock, reset, 1'b1,
      cnt_ff <= 3'(b64e_pkg::GROUP_MAX), "output buffer count out of range")
   `B64E_ASSERT_NEXT(a_drain_continues, clock, reset, rsp_fire && cnt_ff > 3'd1,
      rsp_tvalid, "buffered characters lost")
   `B64E_ASSERT_NEXT(a_load_starts, clock, reset, req_fire && group.count != 3'd0,
      rsp_tvalid && rd_ff == 2'd0, "new group not presented from its first entry")

endmodule
